/* rtl/sine_pwm_duty_generator_macros.svh */
// ---------------------------------------------------------------------------
// Sine PWM duty generator assertion macros
// Shared concurrent assertion forms for the checker.
// ---------------------------------------------------------------------------
`ifndef SINE_PWM_DUTY_GENERATOR_MACROS_SVH
`define SINE_PWM_DUTY_GENERATOR_MACROS_SVH

// same-cycle implication, masked while reset is high
`define SPWM_ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, masked while reset is high
`define SPWM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/spwm_pkg.sv */
// ---------------------------------------------------------------------------
// Sine PWM duty generator package
// Word types, command and register codes, reset values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package spwm_pkg;

  typedef struct packed {
    logic [1:0]  kind;
    logic [16:0] amplitude;
  } spwm_cmd_t;

  typedef struct packed {
    logic [15:0] duty;
    logic [7:0]  point_index;
  } spwm_rsp_t;

  localparam logic [1:0] KIND_TICK    = 2'd0;
  localparam logic [1:0] KIND_SET_AMP = 2'd1;
  localparam logic [1:0] KIND_RESTART = 2'd2;
  localparam logic [1:0] KIND_NONE    = 2'd3;

  localparam logic [1:0] REG_HALF_DUTY   = 2'd0;
  localparam logic [1:0] REG_TICK_DIVIDE = 2'd1;
  localparam logic [1:0] REG_DEAD_SCALE  = 2'd2;

  localparam logic [16:0] FULL_Q16 = 17'h10000;

  localparam logic [14:0] HALF_DUTY_RESET   = 15'd32767;
  localparam logic [7:0]  TICK_DIVIDE_RESET = 8'd1;
  localparam logic [16:0] DEAD_SCALE_RESET  = FULL_Q16;

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

endpackage

/* rtl/spwm_bit_mul.sv */
// ---------------------------------------------------------------------------
// Serial shift-add multiplier
// One multiplier bit per cycle, LSB first; done pulses with the product.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module spwm_bit_mul #(
  parameter int AW = 17,
  parameter int BW = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic             done,
  output logic [AW+BW-1:0] prod
);

  localparam int CW = $clog2(BW);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [AW-1:0] mcand;
  logic [AW-1:0] hi;
  logic [BW-1:0] lo;
  logic [AW:0]   sum;

  assign sum  = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : '0);
  assign prod = {hi, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(BW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // partial sum shifts down into the spent multiplier bits
  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a;
      hi    <= '0;
      lo    <= b;
    end else if (busy) begin
      hi <= sum[AW:1];
      lo <= {sum[0], lo[BW-1:1]};
    end
  end

endmodule

/* rtl/sine_pwm_duty_generator.sv */
// ---------------------------------------------------------------------------
// Sine PWM duty generator
// Divided timer ticks step through a sine table and emit PWM duty words.
// ---------------------------------------------------------------------------
// Flow: a divided tick or a restart starts a duty computation through ST_LOAD,
//   ST_MUL1, ST_MUL2 and ST_FINISH (free output); cmd_stall stays high over that span.
// No new command is taken until the duty word is out; the work is set by the two
//   chained bit-serial multipliers (17 steps amplitude x scale, 30 steps for the final product).
// Other commands leave cmd_stall low. Reset (rst, synchronous) restores control and config registers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sine_pwm_duty_generator
  import spwm_pkg::*;
#(
  parameter int TABLE_SIZE = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cmd_valid,
  output logic        cmd_stall,
  input  spwm_cmd_t   cmd,
  output logic        rsp_valid,
  input  logic        rsp_stall,
  output spwm_rsp_t   rsp,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  localparam int PW = $clog2(TABLE_SIZE);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_LOAD   = 3'd1;
  localparam logic [2:0] ST_MUL1   = 3'd2;
  localparam logic [2:0] ST_MUL2   = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  // Q1.15 samples, magnitude from a Q30 Taylor series on the folded phase
  function automatic logic [TABLE_SIZE*16-1:0] build_sine_rom();
    logic [TABLE_SIZE*16-1:0] rom;
    logic [63:0] p;
    logic [63:0] r;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] mag;
    logic        neg;
    rom = '0;
    for (int i = 0; i < TABLE_SIZE; i++) begin
      p = ((64'(i) << 32) + 64'(TABLE_SIZE / 2)) / 64'(TABLE_SIZE);
      neg = p[31];
      r = p & 64'h7FFF_FFFF;
      if (r > 64'h4000_0000) begin
        r = 64'h8000_0000 - r;
      end
      x = (r * PI_HALF_Q30) >> 30;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (int k = 1; k <= 8; k++) begin
        term = (term * x2) >> 30;
        // scale down by (2k)(2k+1)
        case (k)
          1: term = term / 64'd6;
          2: term = term / 64'd20;
          3: term = term / 64'd42;
          4: term = term / 64'd72;
          5: term = term / 64'd110;
          6: term = term / 64'd156;
          7: term = term / 64'd210;
          default: term = term / 64'd272;
        endcase
        if (k % 2 == 1) begin
          sum = (sum >= term) ? sum - term : 64'd0;
        end else begin
          sum = sum + term;
        end
      end
      mag = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
      if (mag > 64'd32767) begin
        mag = 64'd32767;
      end
      rom[i*16 +: 16] = neg ? 16'(-mag) : 16'(mag);
    end
    return rom;
  endfunction

  localparam logic [TABLE_SIZE*16-1:0] SINE_ROM = build_sine_rom();

  logic [2:0]    state;
  logic [14:0]   half_duty;
  logic [7:0]    tick_divide;
  logic [16:0]   dead_time_scale;
  logic [7:0]    tick_count;
  logic [PW-1:0] wave_point;
  logic [PW-1:0] calc_point;
  logic [16:0]   active_amplitude;
  logic [16:0]   pending_amplitude;
  logic          amplitude_pending;
  logic          sample_neg;

  logic          cmd_accept;
  logic          rsp_free;
  logic [7:0]    tick_inc;
  logic          tick_fire;
  logic          at_crossing;
  logic [PW-1:0] wave_point_inc;
  logic [16:0]   amp_clamped;
  logic [16:0]   scale_clamped;
  logic [15:0]   rom_sample;
  logic          rom_neg;
  logic [14:0]   rom_mag;
  logic [15:0]   swing;
  logic [15:0]   duty;

  logic          mul1_start;
  logic          mul2_start;
  logic          amp_done;
  logic          half_done;
  logic          fin_done;
  logic [33:0]   amp_prod;
  logic [31:0]   half_prod;
  logic [62:0]   fin_prod;

  assign cmd_stall  = (state != ST_IDLE);
  assign cmd_accept = cmd_valid && !cmd_stall;
  assign rsp_free   = !rsp_valid || !rsp_stall;

  assign tick_inc    = tick_count + 8'd1;
  assign tick_fire   = (tick_inc == tick_divide);
  assign at_crossing = (wave_point == '0) || (wave_point == PW'(TABLE_SIZE / 2));
  assign wave_point_inc = (wave_point == PW'(TABLE_SIZE - 1)) ? '0 : wave_point + 1'b1;

  assign amp_clamped   = (cmd.amplitude > FULL_Q16) ? FULL_Q16 : cmd.amplitude;
  assign scale_clamped = (dead_time_scale > FULL_Q16) ? FULL_Q16 : dead_time_scale;

  assign rom_sample = SINE_ROM[{calc_point, 4'b0000} +: 16];
  assign rom_neg    = rom_sample[15];
  assign rom_mag    = 15'(rom_neg ? -rom_sample : rom_sample);

  assign mul1_start = (state == ST_LOAD);
  assign mul2_start = (state == ST_MUL1) && amp_done;

  // amplitude x scale, Q32
  spwm_bit_mul #(.AW(17), .BW(17)) u_mul_amp (
    .clk   (clk),
    .rst   (rst),
    .start (mul1_start),
    .a     (active_amplitude),
    .b     (scale_clamped),
    .done  (amp_done),
    .prod  (amp_prod)
  );

  // half_duty x |sample|, runs alongside the amplitude product
  spwm_bit_mul #(.AW(15), .BW(17)) u_mul_half (
    .clk   (clk),
    .rst   (rst),
    .start (mul1_start),
    .a     (half_duty),
    .b     ({2'b00, rom_mag}),
    .done  (half_done),
    .prod  (half_prod)
  );

  spwm_bit_mul #(.AW(33), .BW(30)) u_mul_fin (
    .clk   (clk),
    .rst   (rst),
    .start (mul2_start),
    .a     (amp_prod[32:0]),
    .b     (half_prod[29:0]),
    .done  (fin_done),
    .prod  (fin_prod)
  );

  assign swing = fin_prod[62:47];
  assign duty  = sample_neg ? {1'b0, half_duty} - swing : {1'b0, half_duty} + swing;

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      half_duty         <= HALF_DUTY_RESET;
      tick_divide       <= TICK_DIVIDE_RESET;
      dead_time_scale   <= DEAD_SCALE_RESET;
      tick_count        <= '0;
      wave_point        <= '0;
      active_amplitude  <= '0;
      pending_amplitude <= '0;
      amplitude_pending <= 1'b0;
      rsp_valid         <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          REG_HALF_DUTY:   half_duty       <= cfg_data[14:0];
          REG_TICK_DIVIDE: tick_divide     <= cfg_data[7:0];
          REG_DEAD_SCALE:  dead_time_scale <= cfg_data;
          default: ;
        endcase
      end

      // the finish step reloads the output word itself
      if (rsp_valid && !rsp_stall && state != ST_FINISH) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (cmd_accept) begin
            case (cmd.kind)
              KIND_TICK: begin
                tick_count <= tick_fire ? 8'd0 : tick_inc;
                if (tick_fire) begin
                  // swap in a pending amplitude only at a zero crossing
                  if (amplitude_pending && at_crossing) begin
                    active_amplitude  <= pending_amplitude;
                    amplitude_pending <= 1'b0;
                  end
                  calc_point <= wave_point;
                  wave_point <= wave_point_inc;
                  state      <= ST_LOAD;
                end
              end
              KIND_SET_AMP: begin
                pending_amplitude <= amp_clamped;
                amplitude_pending <= 1'b1;
              end
              KIND_RESTART: begin
                wave_point <= '0;
                calc_point <= '0;
                state      <= ST_LOAD;
              end
              default: ;
            endcase
          end
        end
        ST_LOAD: begin
          sample_neg <= rom_neg;
          state      <= ST_MUL1;
        end
        ST_MUL1: begin
          if (amp_done && half_done) begin
            state <= ST_MUL2;
          end
        end
        ST_MUL2: begin
          if (fin_done) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // hold the product until the output register frees up
          if (rsp_free) begin
            rsp_valid       <= 1'b1;
            rsp.duty        <= duty;
            rsp.point_index <= 8'(calc_point);
            state           <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/spwm_checker.sv */
// ---------------------------------------------------------------------------
// Sine PWM duty generator checker
// Port-level assertions, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sine_pwm_duty_generator_macros.svh"

module spwm_checker
  import spwm_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      cmd_valid,
  input logic      cmd_stall,
  input spwm_cmd_t cmd,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input spwm_rsp_t rsp
);

  `SPWM_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "stalled duty word changed")

  `SPWM_ASSERT_NEXT(a_quiet_cmd, clk, rst, cmd_valid && !cmd_stall && (cmd.kind == KIND_SET_AMP || cmd.kind == KIND_NONE), !cmd_stall, "non-emitting word left the block busy")

  `SPWM_ASSERT_NEXT(a_restart_busy, clk, rst, cmd_valid && !cmd_stall && cmd.kind == KIND_RESTART, cmd_stall, "restart did not start a duty computation")

  `SPWM_ASSERT_IMPLY(a_rsp_from_work, clk, rst, $rose(rsp_valid), $past(cmd_stall) && !cmd_stall, "duty word appeared outside a computation")

endmodule

bind sine_pwm_duty_generator spwm_checker u_spwm_checker (.*);
